### design/assert_macros.svh
// assertion macros shared by the priority queue bank rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TCPQ_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication
`define TCPQ_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCPQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/tcpq_pkg.sv
// types and codes for the two-class priority queue bank
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ADDED    = 2'd0,
		ST_FULL     = 2'd1,
		ST_DEQUEUED = 2'd2,
		ST_EMPTY    = 2'd3
	} tcpq_status_t;

	// row operation applied by every cell
	typedef enum logic [1:0] {
		OP_NONE,
		OP_ENQ_REG,
		OP_ENQ_URG,
		OP_DEQ
	} tcpq_op_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  queue_index;
		logic [15:0] entry_tag;
		logic        urgent;
	} tcpq_in_t;

	typedef struct packed {
		tcpq_status_t status;
		logic [15:0]  head_tag;
		logic         head_urgent;
		logic [2:0]   occupancy;
	} tcpq_out_t;

endpackage

`default_nettype wire

### design/tcpq_cell.sv
// one slot cell of the queue row: picks its next value from itself, a neighbor or the new entry
// depends on tcpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpq_cell
	import tcpq_pkg::*;
#(
	parameter int TAG_BITS = 16,
	parameter int CW       = 3,
	parameter int IDX      = 0
) (
	input  tcpq_op_t          op,
	input  logic [CW-1:0]     cnt,
	input  logic [TAG_BITS:0] new_entry,
	input  logic [TAG_BITS:0] own,
	input  logic [TAG_BITS:0] prev,
	input  logic [TAG_BITS:0] next,
	input  logic              urg_tail_in,
	output logic              urg_tail_out,
	output logic [TAG_BITS:0] slot_out
);

	localparam int PREV_IDX = (IDX > 0) ? IDX - 1 : 0;

	logic occupied;
	logic prev_urg;
	logic at_pos;

	assign occupied     = CW'(IDX) < cnt;
	// urgent mark seen in this slot or any slot behind it
	assign urg_tail_out = (occupied && own[TAG_BITS]) || urg_tail_in;
	assign prev_urg     = (IDX > 0) && prev[TAG_BITS] && (CW'(PREV_IDX) < cnt);
	assign at_pos       = !urg_tail_out && ((IDX == 0) || prev_urg);

	always_comb begin
		case (op)
			OP_ENQ_REG: begin
				slot_out = (CW'(IDX) == cnt) ? new_entry : own;
			end
			OP_ENQ_URG: begin
				if (urg_tail_out) begin
					slot_out = own;
				end else if (at_pos) begin
					slot_out = new_entry;
				end else begin
					slot_out = prev;
				end
			end
			OP_DEQ: begin
				slot_out = next;
			end
			default: begin
				slot_out = own;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/two_class_priority_queue_bank.sv
// top level of the two-class priority queue bank: row memory, counts, cell row
// depends on tcpq_pkg, tcpq_cell and assert_macros.svh
//
// a transferred command and its row read are registered in stage 1; the result register then gives its result strobe
// no new command is taken while busy, set by the read-modify-write of one row of the slot memory
// reset clears the per-queue counts at once; slot memory is not cleared and needs no sweep
// the receiver cannot stall, a result is shown for one cycle only
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module two_class_priority_queue_bank
	import tcpq_pkg::*;
#(
	parameter int NUM_QUEUES  = 20,
	parameter int QUEUE_DEPTH = 5,
	parameter int TAG_BITS    = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  tcpq_in_t  cmd,
	output logic      done,
	output tcpq_out_t result
);

	// address, count and tag widths; the index compare is one bit wider so the
	// bank size itself fits
	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int IW  = ((QW > 5) ? QW : 5) + 1;
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int OXW = (CW > 3) ? CW : 3;
	localparam int XW  = (TAG_BITS > 16) ? TAG_BITS : 16;

	typedef logic [TAG_BITS:0] slot_t;
	typedef logic [QUEUE_DEPTH-1:0][TAG_BITS:0] row_t;

	// slot memory, one row per queue, mark bit on top of the tag
	row_t row_mem [NUM_QUEUES];

	logic [CW-1:0] counts_q [NUM_QUEUES];

	// stage 1: row read back, command held
	logic                valid_s1;
	logic                in_range_s1;
	logic                kind_s1;
	logic                urgent_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [QW-1:0]       addr_s1;
	row_t                row_s1;

	logic done_q;
	tcpq_out_t result_q;

	logic          accept;
	logic [IW-1:0] idx_wide;
	logic          in_range;
	logic [QW-1:0] rd_addr;
	logic [XW-1:0] tag_wide;

	assign accept   = start && !busy;
	assign idx_wide = IW'(cmd.queue_index);
	assign in_range = idx_wide < IW'(NUM_QUEUES);
	assign rd_addr  = in_range ? idx_wide[QW-1:0] : '0;
	assign tag_wide = XW'(cmd.entry_tag);

	// command transfer and registered row read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_range;
			kind_s1     <= cmd.kind;
			urgent_s1   <= cmd.urgent;
			tag_s1      <= tag_wide[TAG_BITS-1:0];
			addr_s1     <= rd_addr;
			row_s1      <= row_mem[rd_addr];
		end
	end

	// decode against the current count
	logic [CW-1:0] cnt;
	logic [CW-1:0] cnt_new;
	logic          is_full;
	logic          is_empty;
	tcpq_op_t      op;
	tcpq_status_t  status;

	assign cnt      = counts_q[addr_s1];
	assign is_full  = cnt >= CW'(QUEUE_DEPTH);
	assign is_empty = cnt == '0;

	always_comb begin
		op      = OP_NONE;
		cnt_new = cnt;
		if (!in_range_s1) begin
			status = (kind_s1 == KIND_DEQ) ? ST_EMPTY : ST_FULL;
		end else if (kind_s1 == KIND_ENQ) begin
			if (is_full) begin
				status = ST_FULL;
			end else begin
				status  = ST_ADDED;
				op      = urgent_s1 ? OP_ENQ_URG : OP_ENQ_REG;
				cnt_new = cnt + CW'(1);
			end
		end else begin
			if (is_empty) begin
				status = ST_EMPTY;
			end else begin
				status  = ST_DEQUEUED;
				op      = OP_DEQ;
				cnt_new = cnt - CW'(1);
			end
		end
	end

	// row of cells, each slot looks at its neighbors; urgent marks chain toward the head
	slot_t                  new_entry;
	row_t                   row_next;
	logic [QUEUE_DEPTH-1:0] urg_tail;

	assign new_entry = {urgent_s1, tag_s1};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int PI = (i > 0) ? i - 1 : 0;
		localparam int NI = (i < QUEUE_DEPTH - 1) ? i + 1 : QUEUE_DEPTH - 1;

		tcpq_cell #(
			.TAG_BITS (TAG_BITS),
			.CW       (CW),
			.IDX      (i)
		) u_cell (
			.op           (op),
			.cnt          (cnt),
			.new_entry    (new_entry),
			.own          (row_s1[i]),
			.prev         (row_s1[PI]),
			.next         (row_s1[NI]),
			.urg_tail_in  ((i < QUEUE_DEPTH - 1) ? urg_tail[NI] : 1'b0),
			.urg_tail_out (urg_tail[i]),
			.slot_out     (row_next[i])
		);
	end

	// write back row and count
	logic row_write;

	assign row_write = valid_s1 && (op != OP_NONE);

	always_ff @(posedge clk) begin
		if (row_write) begin
			row_mem[addr_s1] <= row_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				counts_q[q] <= '0;
			end
		end else if (row_write) begin
			counts_q[addr_s1] <= cnt_new;
		end
	end

	// result register
	logic [XW-1:0]  head_wide;
	logic [OXW-1:0] occ_wide;

	assign head_wide = XW'(row_s1[0][TAG_BITS-1:0]);
	assign occ_wide  = in_range_s1 ? OXW'(cnt_new) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.status      <= status;
			result_q.head_tag    <= (op == OP_DEQ) ? head_wide[15:0] : 16'd0;
			result_q.head_urgent <= (op == OP_DEQ) ? row_s1[0][TAG_BITS] : 1'b0;
			result_q.occupancy   <= occ_wide[2:0];
		end
	end

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;

	// checks
	`TCPQ_ASSERT_NEXT(a_accept_to_s1, accept, valid_s1, "transfer did not reach stage 1")
	`TCPQ_ASSERT_NEXT(a_s1_to_done, valid_s1, done_q && !valid_s1, "stage 1 did not produce one result")
	`TCPQ_ASSERT_IMP(a_count_bound, valid_s1, cnt <= CW'(QUEUE_DEPTH), "queue count beyond depth")
	`TCPQ_ASSERT_IMP(a_urgent_prefix, valid_s1 && (op == OP_DEQ) && !row_s1[0][TAG_BITS],
		!urg_tail[0], "urgent entry queued behind a regular head")
	`TCPQ_ASSERT_IMP(a_no_head_on_add, done_q && (result_q.status != ST_DEQUEUED),
		(result_q.head_tag == 16'd0) && !result_q.head_urgent, "head fields set without dequeue")

endmodule

`default_nettype wire
